### hdl/tga_pkg.sv
//------------------------------------------------------------------------------
// tga_pkg
// Shared types and constants of the TGA run-length pixel decoder.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tga_pkg;

    localparam int DIMENSION_BITS_DEF = 15;
    localparam int QUEUE_DEPTH_DEF    = 4;
    localparam int CFG_INDEX_BITS     = 2;
    localparam int CFG_DATA_BITS      = 16;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_BYTES_PER_PIXEL = 2'd0,
        CFG_IMAGE_WIDTH     = 2'd1,
        CFG_IMAGE_HEIGHT    = 2'd2,
        CFG_UNUSED          = 2'd3
    } t_cfg_index;

    localparam logic [2:0] BPP_RESET    = 3'd4;
    localparam logic [2:0] BPP_BGR      = 3'd3;
    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
    localparam logic [8:0] RUN_BIAS     = 9'd127;

    // Finished pixel, as handed from the parser to the output stage.
    typedef struct packed {
        logic [23:0] held;
        logic [7:0]  last_byte;
        logic        bgr;
        logic [7:0]  repeat_count;
        logic        image_done;
        logic        overrun;
    } t_pix_rec;

endpackage

`default_nettype wire

### hdl/tga_rle_pixel_decoder.sv
//------------------------------------------------------------------------------
// tga_rle_pixel_decoder
// Run-length decoder for TGA image data: bytes in, pixels with repeat
// counts out.
//------------------------------------------------------------------------------
// Input is a queue-style channel: a byte is taken when push is high and
// full is low. Results come out as a queue: while empty is low the oldest
// pixel is on the outputs, and pop with empty low takes it.
// One byte is taken every cycle while full is low; a pixel result appears
// after its last byte (3 or 4 bytes per pixel, plus one header byte per
// packet). The parser handles each byte combinationally, so the rate is
// one byte per clock. Empty falls once the record has passed the queue
// into the output register. A four-entry record queue plus the output
// register absorb a stalled receiver; full rises when the queue is full.
// Configuration writes (valid and ready, index 0 bytes per pixel, 1
// width, 2 height) restart decoding; full is high for the one cycle in
// which the pixel count is reloaded from width times height.
// Reset: bytes per pixel 4, width and height 1, header expected, no
// results waiting.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tga_rle_pixel_decoder
    import tga_pkg::*;
#(
    parameter int DIMENSION_BITS = DIMENSION_BITS_DEF,
    parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      push,
    output logic                           full,
    input  wire logic [7:0]                i_stream_byte,
    output logic                           empty,
    input  wire logic                      pop,
    output logic [7:0]                     o_pix_blue,
    output logic [7:0]                     o_pix_green,
    output logic [7:0]                     o_pix_red,
    output logic [7:0]                     o_pix_alpha,
    output logic [7:0]                     o_repeat_count,
    output logic                           o_image_done,
    output logic                           o_overrun,
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  i_cfg_data
);

    logic     q_full;
    logic     rec_push;
    t_pix_rec rec_in;
    logic     q_nonempty;
    logic     q_pop;
    t_pix_rec rec_out;

    tga_front #(
        .DIMENSION_BITS(DIMENSION_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_stream_byte(i_stream_byte),
        .i_q_full     (q_full),
        .o_full       (full),
        .o_rec_push   (rec_push),
        .o_rec        (rec_in),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    tga_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (rec_push),
        .i_rec     (rec_in),
        .o_full    (q_full),
        .i_pop     (q_pop),
        .o_nonempty(q_nonempty),
        .o_rec     (rec_out)
    );

    tga_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_nonempty  (q_nonempty),
        .i_rec         (rec_out),
        .o_q_pop       (q_pop),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_pix_blue    (o_pix_blue),
        .o_pix_green   (o_pix_green),
        .o_pix_red     (o_pix_red),
        .o_pix_alpha   (o_pix_alpha),
        .o_repeat_count(o_repeat_count),
        .o_image_done  (o_image_done),
        .o_overrun     (o_overrun)
    );

endmodule

`default_nettype wire

### hdl/tga_front.sv
//------------------------------------------------------------------------------
// tga_front
// Configuration registers, packet parser and pixel counters; emits one
// record per finished pixel.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tga_front
    import tga_pkg::*;
#(
    parameter int DIMENSION_BITS = DIMENSION_BITS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_push,
    input  wire logic [7:0]                i_stream_byte,
    input  wire logic                      i_q_full,
    output logic                           o_full,
    output logic                           o_rec_push,
    output t_pix_rec                       o_rec,
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  i_cfg_data
);

    localparam int IL = 2 * DIMENSION_BITS;

    logic [2:0]                r_bpp;
    logic [DIMENSION_BITS-1:0] r_width;
    logic [DIMENSION_BITS-1:0] r_height;
    logic                      r_reload;

    logic        r_expect_header, n_expect_header;
    logic        r_run, n_run;
    logic        r_clipped, n_clipped;
    logic [7:0]  r_packet_left, n_packet_left;
    logic [1:0]  r_pos, n_pos;
    logic [23:0] r_held, n_held;
    logic [IL-1:0] r_image_left, n_image_left;

    logic [DIMENSION_BITS-1:0] w_dim;
    logic [DIMENSION_BITS-1:0] h_dim;
    logic [IL-1:0]             total;
    logic                      cfg_we;
    logic                      accept;
    logic                      bgr;
    logic                      pix_last;
    logic [8:0]                hdr_cnt;
    logic                      hdr_clip;
    logic [7:0]                rep;
    logic [IL-1:0]             rep_ext;
    logic [IL-1:0]             left_sub;
    logic                      done;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && (t_cfg_index'(i_cfg_index) != CFG_UNUSED);
    assign o_full      = i_q_full || r_reload;
    assign accept      = i_push && !o_full;

    assign w_dim = (r_width == '0)  ? DIMENSION_BITS'(1) : r_width;
    assign h_dim = (r_height == '0) ? DIMENSION_BITS'(1) : r_height;
    assign total = IL'(w_dim) * IL'(h_dim);

    assign bgr      = (r_bpp == BPP_BGR);
    assign pix_last = bgr ? (r_pos == 2'd2) : (r_pos == 2'd3);
    assign hdr_cnt  = i_stream_byte[7] ? ({1'b0, i_stream_byte} - RUN_BIAS)
                                       : ({1'b0, i_stream_byte} + 9'd1);
    assign hdr_clip = IL'(hdr_cnt) > r_image_left;
    assign rep      = r_run ? r_packet_left : 8'd1;
    assign rep_ext  = IL'(rep);
    assign left_sub = (r_image_left >= rep_ext) ? (r_image_left - rep_ext) : '0;
    assign done     = (left_sub == '0);

    always_comb begin
        n_expect_header = r_expect_header;
        n_run           = r_run;
        n_clipped       = r_clipped;
        n_packet_left   = r_packet_left;
        n_pos           = r_pos;
        n_held          = r_held;
        n_image_left    = r_image_left;
        o_rec_push      = 1'b0;
        o_rec.held         = r_held;
        o_rec.last_byte    = i_stream_byte;
        o_rec.bgr          = bgr;
        o_rec.repeat_count = rep;
        o_rec.image_done   = done;
        o_rec.overrun      = r_clipped;
        if (accept) begin
            if (r_expect_header) begin
                n_run           = i_stream_byte[7];
                n_clipped       = hdr_clip;
                n_packet_left   = hdr_clip ? r_image_left[7:0] : hdr_cnt[7:0];
                n_expect_header = 1'b0;
                n_pos           = 2'd0;
                n_held          = '0;
            end else if (!pix_last) begin
                unique case (r_pos)
                    2'd0:    n_held[7:0]   = i_stream_byte;
                    2'd1:    n_held[15:8]  = i_stream_byte;
                    default: n_held[23:16] = i_stream_byte;
                endcase
                n_pos = r_pos + 2'd1;
            end else begin
                o_rec_push    = 1'b1;
                n_pos         = 2'd0;
                n_held        = '0;
                n_packet_left = r_run ? 8'd0
                              : ((r_packet_left != 8'd0) ? r_packet_left - 8'd1 : 8'd0);
                n_image_left  = left_sub;
                if (n_packet_left == 8'd0) begin
                    n_expect_header = 1'b1;
                end
                if (done) begin
                    n_image_left    = total;
                    n_expect_header = 1'b1;
                    n_packet_left   = 8'd0;
                    n_clipped       = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpp           <= BPP_RESET;
            r_width         <= DIMENSION_BITS'(1);
            r_height        <= DIMENSION_BITS'(1);
            r_reload        <= 1'b0;
            r_expect_header <= 1'b1;
            r_run           <= 1'b0;
            r_clipped       <= 1'b0;
            r_packet_left   <= '0;
            r_pos           <= '0;
            r_held          <= '0;
            r_image_left    <= IL'(1);
        end else if (cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_BYTES_PER_PIXEL: r_bpp    <= i_cfg_data[2:0];
                CFG_IMAGE_WIDTH:     r_width  <= i_cfg_data[DIMENSION_BITS-1:0];
                CFG_IMAGE_HEIGHT:    r_height <= i_cfg_data[DIMENSION_BITS-1:0];
                default:             r_bpp    <= r_bpp;
            endcase
            r_reload        <= 1'b1;
            r_expect_header <= 1'b1;
            r_run           <= 1'b0;
            r_clipped       <= 1'b0;
            r_packet_left   <= '0;
            r_pos           <= '0;
            r_held          <= '0;
        end else if (r_reload) begin
            r_reload     <= 1'b0;
            r_image_left <= total;
        end else begin
            r_expect_header <= n_expect_header;
            r_run           <= n_run;
            r_clipped       <= n_clipped;
            r_packet_left   <= n_packet_left;
            r_pos           <= n_pos;
            r_held          <= n_held;
            r_image_left    <= n_image_left;
        end
    end

    a_image_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_image_left != '0)
        else $error("image pixel count reached zero without reload");

    a_packet_open_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_expect_header |-> (r_packet_left != 8'd0))
        else $error("packet open with no pixels left");

    a_rec_repeat_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rec_push |-> (o_rec.repeat_count != 8'd0) && !r_reload)
        else $error("pixel record with zero repeat count");

endmodule

`default_nettype wire

### hdl/tga_queue.sv
//------------------------------------------------------------------------------
// tga_queue
// Short register queue of pixel records between parser and output stage.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tga_queue
    import tga_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  wire t_pix_rec i_rec,
    output logic          o_full,
    input  wire logic     i_pop,
    output logic          o_nonempty,
    output t_pix_rec      o_rec
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_pix_rec        r_mem [DEPTH];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [CW-1:0]   r_count;
    logic            do_push;
    logic            do_pop;

    assign o_full     = (r_count == CW'(DEPTH));
    assign o_nonempty = (r_count != '0);
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && o_nonempty;
    assign o_rec      = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count beyond depth");

    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_push |=> o_nonempty)
        else $error("pushed record lost");

endmodule

`default_nettype wire

### hdl/tga_back.sv
//------------------------------------------------------------------------------
// tga_back
// Output stage: formats pixel records into result fields and holds the
// oldest result until it is popped.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tga_back
    import tga_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_q_nonempty,
    input  wire t_pix_rec i_rec,
    output logic          o_q_pop,
    input  wire logic     i_pop,
    output logic          o_empty,
    output logic [7:0]    o_pix_blue,
    output logic [7:0]    o_pix_green,
    output logic [7:0]    o_pix_red,
    output logic [7:0]    o_pix_alpha,
    output logic [7:0]    o_repeat_count,
    output logic          o_image_done,
    output logic          o_overrun
);

    logic r_valid;

    assign o_empty = !r_valid;
    assign o_q_pop = i_q_nonempty && (!r_valid || i_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            o_pix_blue     <= i_rec.held[7:0];
            o_pix_green    <= i_rec.held[15:8];
            o_pix_red      <= i_rec.bgr ? i_rec.last_byte : i_rec.held[23:16];
            o_pix_alpha    <= i_rec.bgr ? ALPHA_OPAQUE : i_rec.last_byte;
            o_repeat_count <= i_rec.repeat_count;
            o_image_done   <= i_rec.image_done;
            o_overrun      <= i_rec.overrun;
        end
    end

    a_refill_after_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pop && r_valid && i_q_nonempty) |=> r_valid)
        else $error("waiting record not moved to output");

endmodule

`default_nettype wire

### bench/tga_pixel_checker.sv
//------------------------------------------------------------------------------
// tga_pixel_checker
// Watches the byte, configuration and pixel channels of the TGA run-length
// decoder. It decodes every accepted byte on its own and compares each
// popped pixel, field by field, with the oldest pixel it has decoded.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module tga_pixel_checker
    import tga_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  logic                      i_full,
    input  logic [7:0]                i_stream_byte,
    input  logic                      i_empty,
    input  logic                      i_pop,
    input  logic [7:0]                i_pix_blue,
    input  logic [7:0]                i_pix_green,
    input  logic [7:0]                i_pix_red,
    input  logic [7:0]                i_pix_alpha,
    input  logic [7:0]                i_repeat_count,
    input  logic                      i_image_done,
    input  logic                      i_overrun,
    input  logic                      i_cfg_valid,
    input  logic                      i_cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    output int                        o_errors,
    output int                        o_pending
);

    localparam int PIX_BITS = 2 * DIMENSION_BITS_DEF;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] alpha;
        logic [7:0] rep;
        logic       done;
        logic       ovr;
    } t_pixel;

    logic [2:0]               bpp_reg;
    logic [CFG_DATA_BITS-1:0] width_reg;
    logic [CFG_DATA_BITS-1:0] height_reg;

    logic                hdr_wait;
    logic                in_run;
    logic                clipped;
    logic [7:0]          pkt_left;
    logic [1:0]          byte_pos;
    logic [23:0]         held;
    logic [PIX_BITS-1:0] pix_left;

    t_pixel pixels_due[$];
    int     mismatches = 0;

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    // zero dimension counts as one; wide values keep the low bits only
    function automatic logic [PIX_BITS-1:0] image_size();
        logic [PIX_BITS-1:0] w;
        logic [PIX_BITS-1:0] h;
        w = PIX_BITS'(width_reg[DIMENSION_BITS_DEF-1:0]);
        h = PIX_BITS'(height_reg[DIMENSION_BITS_DEF-1:0]);
        if (w == 0) w = PIX_BITS'(1);
        if (h == 0) h = PIX_BITS'(1);
        return w * h;
    endfunction

    task automatic restart_decode();
        hdr_wait = 1'b1;
        in_run   = 1'b0;
        clipped  = 1'b0;
        pkt_left = '0;
        byte_pos = '0;
        held     = '0;
        pix_left = image_size();
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [CFG_DATA_BITS-1:0] value);
        case (idx)
            CFG_BYTES_PER_PIXEL: begin
                bpp_reg = value[2:0];
                restart_decode();
            end
            CFG_IMAGE_WIDTH: begin
                width_reg = value;
                restart_decode();
            end
            CFG_IMAGE_HEIGHT: begin
                height_reg = value;
                restart_decode();
            end
            default: begin
            end
        endcase
    endtask

    task automatic decode_byte(input logic [7:0] b);
        logic [8:0] n;
        logic [7:0] rep;
        logic       bgr;
        t_pixel     px;
        bgr = (bpp_reg == BPP_BGR);
        if (hdr_wait) begin
            in_run = b[7];
            n = in_run ? {1'b0, b} - RUN_BIAS : {1'b0, b} + 9'd1;
            clipped = n > pix_left;
            if (clipped) n = pix_left[8:0];
            pkt_left = n[7:0];
            hdr_wait = 1'b0;
            byte_pos = '0;
            held     = '0;
        end else if ({1'b0, byte_pos} + 3'd1 < (bgr ? 3'd3 : 3'd4)) begin
            held[byte_pos*8 +: 8] = b;
            byte_pos = byte_pos + 2'd1;
        end else begin
            px.blue  = held[7:0];
            px.green = held[15:8];
            px.red   = bgr ? b : held[23:16];
            px.alpha = bgr ? ALPHA_OPAQUE : b;
            byte_pos = '0;
            held     = '0;
            if (in_run) begin
                rep      = pkt_left;
                pkt_left = '0;
            end else begin
                rep      = 8'd1;
                pkt_left = (pkt_left > 0) ? pkt_left - 8'd1 : 8'd0;
            end
            pix_left = (pix_left >= rep) ? pix_left - rep : '0;
            if (pkt_left == 0) hdr_wait = 1'b1;
            px.rep  = rep;
            px.done = (pix_left == 0);
            px.ovr  = clipped;
            pixels_due.insert(pixels_due.size(), px);
            if (px.done) begin
                pix_left = image_size();
                hdr_wait = 1'b1;
                pkt_left = '0;
                clipped  = 1'b0;
            end
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    task automatic check_pixel();
        t_pixel want;
        if (pixels_due.size() == 0) begin
            report_mismatch("pixel with no request behind it", 1, 0);
            return;
        end
        want = pixels_due.pop_front();
        if (i_pix_blue != want.blue)
            report_mismatch("blue", int'(i_pix_blue), int'(want.blue));
        if (i_pix_green != want.green)
            report_mismatch("green", int'(i_pix_green), int'(want.green));
        if (i_pix_red != want.red)
            report_mismatch("red", int'(i_pix_red), int'(want.red));
        if (i_pix_alpha != want.alpha)
            report_mismatch("alpha", int'(i_pix_alpha), int'(want.alpha));
        if (i_repeat_count != want.rep)
            report_mismatch("repeat count", int'(i_repeat_count), int'(want.rep));
        if (i_image_done != want.done)
            report_mismatch("image done", int'(i_image_done), int'(want.done));
        if (i_overrun != want.ovr)
            report_mismatch("overrun", int'(i_overrun), int'(want.ovr));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            bpp_reg    = BPP_RESET;
            width_reg  = CFG_DATA_BITS'(1);
            height_reg = CFG_DATA_BITS'(1);
            restart_decode();
            pixels_due.delete();
        end else begin
            if (i_pop && !i_empty) check_pixel();
            if (i_cfg_valid && i_cfg_ready) write_reg(t_cfg_index'(i_cfg_index), i_cfg_data);
            if (i_push && !i_full) decode_byte(i_stream_byte);
        end
        o_pending <= pixels_due.size();
        o_errors  <= mismatches;
    end

endmodule

### bench/tga_rle_pixel_decoder_tb.sv
//------------------------------------------------------------------------------
// tga_rle_pixel_decoder_tb
// Drives coded TGA pixel data into the run-length decoder under a series of
// pixel sizes and image dimensions: a directed opening, then packets with
// random content, noise and cut-short packets, with random stalls on both
// sides and one long receiver stall. A separate checker predicts and
// compares every pixel.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module tga_rle_pixel_decoder_tb;
    import tga_pkg::*;

    localparam int NUM_PHASES     = 11;
    localparam int BYTES_PER_PASS = 44;
    localparam int LONG_HOLD      = 300;
    localparam int STALL_LIMIT    = 2000;
    localparam int SETTLE_CYCLES  = 8;

    logic                      clk;
    logic                      rst_n;
    logic                      push;
    logic                      full;
    logic [7:0]                stream_byte;
    logic                      empty;
    logic                      pop;
    logic [7:0]                pix_blue;
    logic [7:0]                pix_green;
    logic [7:0]                pix_red;
    logic [7:0]                pix_alpha;
    logic [7:0]                repeat_count;
    logic                      image_done;
    logic                      overrun;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    int error_count;
    int pixels_pending;
    int stall_cycles;
    int bytes_sent  = 0;
    int px_bytes    = 4;
    bit idling_on   = 1'b1;
    bit hold_request = 1'b0;
    bit hold_done   = 1'b0;

    tga_rle_pixel_decoder uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .push           (push),
        .full           (full),
        .i_stream_byte  (stream_byte),
        .empty          (empty),
        .pop            (pop),
        .o_pix_blue     (pix_blue),
        .o_pix_green    (pix_green),
        .o_pix_red      (pix_red),
        .o_pix_alpha    (pix_alpha),
        .o_repeat_count (repeat_count),
        .o_image_done   (image_done),
        .o_overrun      (overrun),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    tga_pixel_checker pixel_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_push         (push),
        .i_full         (full),
        .i_stream_byte  (stream_byte),
        .i_empty        (empty),
        .i_pop          (pop),
        .i_pix_blue     (pix_blue),
        .i_pix_green    (pix_green),
        .i_pix_red      (pix_red),
        .i_pix_alpha    (pix_alpha),
        .i_repeat_count (repeat_count),
        .i_image_done   (image_done),
        .i_overrun      (overrun),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_errors       (error_count),
        .o_pending      (pixels_pending)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // nothing accepted on any channel for too long ends the run
    always @(posedge clk) begin
        if (!rst_n) begin
            stall_cycles <= 0;
        end else if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // receiver
    initial begin
        pop <= 1'b0;
        wait (rst_n);
        forever begin
            if (hold_request && !hold_done) begin
                pop <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_done = 1'b1;
            end else if (idling_on && $urandom_range(0, 5) == 0) begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end else begin
                pop <= 1'b1;
                @(posedge clk);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        if (idling_on && $urandom_range(0, 5) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        push        <= 1'b1;
        stream_byte <= b;
        do @(posedge clk); while (full);
        bytes_sent++;
    endtask

    // mostly well-formed packets; some noise bytes and cut-short packets
    task automatic send_packet();
        logic [7:0] b;
        int         count;
        int         npix;
        int         nbytes;
        bit         run;
        if ($urandom_range(0, 9) == 0) begin
            b = 8'($urandom_range(0, 255));
            send_byte(b);
            return;
        end
        run   = ($urandom_range(0, 1) == 1);
        count = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 6);
        b     = 8'(run ? count + 127 : count - 1);
        send_byte(b);
        npix   = run ? 1 : ((count > 12) ? 12 : count);
        nbytes = npix * px_bytes;
        if ($urandom_range(0, 9) == 0) nbytes = $urandom_range(0, nbytes - 1);
        repeat (nbytes) begin
            b = 8'($urandom_range(0, 255));
            send_byte(b);
        end
    endtask

    task automatic settle(input int tail);
        push <= 1'b0;
        do @(posedge clk); while (pixels_pending != 0);
        repeat (tail) @(posedge clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [CFG_DATA_BITS-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
    endtask

    initial begin
        logic [7:0]               directed[$];
        logic [CFG_DATA_BITS-1:0] bpp_val;
        logic [CFG_DATA_BITS-1:0] w_val;
        logic [CFG_DATA_BITS-1:0] h_val;
        int                       phase_end;

        rst_n       <= 1'b0;
        push        <= 1'b0;
        stream_byte <= '0;
        cfg_valid   <= 1'b0;
        cfg_index   <= CFG_BYTES_PER_PIXEL;
        cfg_data    <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: four-byte pixels, 1x1 image; raw packet of 128 clipped to one
        directed = '{8'h7F, 8'h00, 8'hFF, 8'h80, 8'h7F};
        foreach (directed[k]) send_byte(directed[k]);
        settle(SETTLE_CYCLES);

        // three-byte pixels, 3x2 image: run of one, raw of two, run of 128 clipped
        write_reg(CFG_BYTES_PER_PIXEL, 16'd3);
        write_reg(CFG_IMAGE_WIDTH, 16'd3);
        write_reg(CFG_IMAGE_HEIGHT, 16'd2);
        cfg_valid <= 1'b0;
        px_bytes = 3;
        directed = '{8'h80, 8'h00, 8'h00, 8'h00,
                     8'h01, 8'hFF, 8'hFF, 8'hFF, 8'h55, 8'hAA, 8'h0F,
                     8'hFF, 8'h12, 8'h34, 8'h56};
        foreach (directed[k]) send_byte(directed[k]);
        settle(SETTLE_CYCLES);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: begin
                    bpp_val = 16'd3;
                    w_val   = 16'd0;
                    h_val   = 16'd0;
                end
                1: begin
                    bpp_val = 16'd4;
                    w_val   = 16'd32767;
                    h_val   = 16'd32767;
                end
                2: begin
                    bpp_val = 16'd7;
                    w_val   = 16'h8002;
                    h_val   = 16'h8003;
                end
                3: begin
                    bpp_val = 16'd0;
                    w_val   = 16'd1;
                    h_val   = CFG_DATA_BITS'($urandom_range(20, 200));
                end
                4: begin
                    bpp_val = 16'hFFFB;
                    w_val   = 16'hFFFF;
                    h_val   = 16'd1;
                end
                default: begin
                    bpp_val = ($urandom_range(0, 3) == 0)
                            ? CFG_DATA_BITS'($urandom_range(0, 65535))
                            : CFG_DATA_BITS'($urandom_range(3, 4));
                    w_val   = CFG_DATA_BITS'($urandom_range(1, 10));
                    h_val   = CFG_DATA_BITS'($urandom_range(1, 10));
                end
            endcase
            idling_on = (phase < NUM_PHASES - 2);
            write_reg(CFG_BYTES_PER_PIXEL, bpp_val);
            write_reg(CFG_IMAGE_WIDTH, w_val);
            write_reg(CFG_IMAGE_HEIGHT, h_val);
            if (phase == 5) write_reg(CFG_UNUSED, CFG_DATA_BITS'($urandom_range(0, 65535)));
            cfg_valid <= 1'b0;
            px_bytes = (bpp_val[2:0] == BPP_BGR) ? 3 : 4;
            if (phase == 2) hold_request = 1'b1;
            phase_end = bytes_sent + BYTES_PER_PASS;
            while (bytes_sent < phase_end) send_packet();
            settle(SETTLE_CYCLES);
        end

        @(negedge clk);
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
